### rtl/core/sset_pkg.sv
package sset_pkg;

    localparam int unsigned DEFAULT_DEPTH = 64;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned RIDX_W        = 6;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned CAP_W         = 7;
    localparam int unsigned COUNT_OUT_W   = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUP       = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key_value;
        logic [RIDX_W-1:0]       read_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [COUNT_OUT_W-1:0]  entry_count;
        logic signed [KEY_W-1:0] read_value;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    advance;
        logic    write_carry;
        logic    write_back;
        logic    count_inc;
        logic    count_dec;
        logic    set_status;
        status_t status_code;
        logic    load_read;
        logic    load_result;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t command;
        logic full;
        logic at_end;
        logic key_eq;
        logic key_ge;
        logic idx_ok;
        logic result_free;
    } dp_stat_t;

endpackage

### rtl/core/sorted_set_insert_delete.sv
// Sorted set of distinct signed 32-bit keys, kept ascending in a table with one write
// port and one registered read port.
// Input channel (item_valid/item_stall/item) carries insert, delete or read transactions;
// output channel (result_valid/result_stall/result) returns one result per transaction
// with status, entry count after the operation and the read value (zero unless a read).
// config_write/config_data set the capacity limit, which must be written only while the
// block is idle; the block itself does not enforce this. Insert and delete walk the
// table one entry per cycle through the read port, searching and then shifting in a
// single pass; a duplicate or a missing key ends the walk at its position. A read, a
// full insert or an unused command does not walk the table. The next transaction is
// taken in the cycle after the result is loaded.
// The input is stalled from accept until the result is loaded. A finished result sits
// in an output register; while the receiver stalls it, the next result is held back and
// the input stays stalled until the first has been taken.
// Reset clears the entry count and sets the capacity limit to 64; table contents are
// not cleared, since only entries below the count are ever read.
module sorted_set_insert_delete #(
    parameter int unsigned DEPTH = sset_pkg::DEFAULT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  sset_pkg::item_t            item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output sset_pkg::result_t          result,
    input  logic                       config_write,
    input  logic [sset_pkg::CAP_W-1:0] config_data
);
    import sset_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sset_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    sset_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .config_write (config_write),
        .config_data  (config_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### rtl/core/sset_ctrl.sv
module sset_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sset_pkg::dp_stat_t stat,
    output sset_pkg::dp_cmd_t  cmd
);
    import sset_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = ST_OK;
        item_stall      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.command)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_SEARCH;
                        end
                    end
                    CMD_DELETE:
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_SEARCH;
                    end
                    CMD_READ:
                        state_next = S_READ;
                    CMD_NOP:
                        state_next = S_DONE;
                endcase
            end
            S_READ:
            begin
                if (stat.idx_ok)
                    cmd.load_read = 1'b1;
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_BAD_INDEX;
                end
                state_next = S_DONE;
            end
            S_SEARCH:
            begin
                if (stat.command == CMD_INSERT)
                begin
                    priority if (stat.at_end)
                    begin
                        cmd.write_carry = 1'b1;
                        cmd.count_inc   = 1'b1;
                        state_next      = S_DONE;
                    end
                    else if (stat.key_ge && stat.key_eq)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DUP;
                        state_next      = S_DONE;
                    end
                    else if (stat.key_ge)
                    begin
                        // place the key, carry the displaced entry upward
                        cmd.write_carry = 1'b1;
                        cmd.advance     = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                        cmd.advance = 1'b1;
                end
                else
                begin
                    priority if (stat.at_end)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else if (stat.key_ge && stat.key_eq)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_SHIFT;
                    end
                    else if (stat.key_ge)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                        cmd.advance = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.command == CMD_INSERT)
                begin
                    cmd.write_carry = 1'b1;
                    if (stat.at_end)
                    begin
                        cmd.count_inc = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                        cmd.advance = 1'b1;
                end
                else
                begin
                    if (stat.at_end)
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.write_back = 1'b1;
                        cmd.advance    = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (stat.result_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/core/sset_dp.sv
module sset_dp #(
    parameter int unsigned DEPTH = sset_pkg::DEFAULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sset_pkg::item_t              item,
    input  logic                         config_write,
    input  logic [sset_pkg::CAP_W-1:0]   config_data,
    input  sset_pkg::dp_cmd_t            cmd,
    output sset_pkg::dp_stat_t           stat,
    input  logic                         result_stall,
    output logic                         result_valid,
    output sset_pkg::result_t            result
);
    import sset_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic signed [KEY_W-1:0] mem [DEPTH];

    cmd_t                    cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [RIDX_W-1:0]       ridx_reg;
    logic [CAP_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        ptr_next;
    logic [CNT_W-1:0]        pos_reg;
    logic signed [KEY_W-1:0] rdata_reg;
    logic signed [KEY_W-1:0] carry_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic signed [KEY_W-1:0] rval_reg;
    result_t                 result_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;

    logic                    wr_en;
    logic [CNT_W-1:0]        wr_pos;
    logic signed [KEY_W-1:0] wr_data;
    logic [CMP_W-1:0]        cap_ext;
    logic [CMP_W-1:0]        cap_eff;
    logic [CMP_W-1:0]        depth_ext;

    // table memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_pos[IDX_W-1:0]] <= wr_data;
        rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    assign wr_en   = cmd.write_carry | cmd.write_back;
    assign wr_pos  = cmd.write_back ? (pos_reg - CNT_W'(1)) : pos_reg;
    assign wr_data = cmd.write_back ? rdata_reg : carry_reg;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load_item)
            ptr_next = (cmd_t'(item.command) == CMD_READ) ? CNT_W'(item.read_index) : '0;
        else if (cmd.advance)
            ptr_next = ptr_reg + CNT_W'(1);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.count_dec)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_result)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= CAP_RESET;
            count_reg        <= '0;
            ptr_reg          <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (config_write)
                cap_reg <= config_data;
            count_reg        <= count_next;
            ptr_reg          <= ptr_next;
            pos_reg          <= ptr_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg    <= cmd_t'(item.command);
            key_reg    <= item.key_value;
            ridx_reg   <= item.read_index;
            carry_reg  <= item.key_value;
            status_reg <= ST_OK;
            rval_reg   <= '0;
        end
        else
        begin
            if (cmd.write_carry)
                carry_reg <= rdata_reg;
            if (cmd.set_status)
                status_reg <= cmd.status_code;
            if (cmd.load_read)
                rval_reg <= rdata_reg;
        end
        if (cmd.load_result)
        begin
            result_reg.status      <= status_reg;
            result_reg.entry_count <= COUNT_OUT_W'(count_reg);
            result_reg.read_value  <= rval_reg;
        end
    end

    assign cap_ext   = CMP_W'(cap_reg);
    assign depth_ext = CMP_W'(DEPTH);
    assign cap_eff   = (cap_ext < depth_ext) ? cap_ext : depth_ext;

    assign stat.command     = cmd_reg;
    assign stat.full        = (CMP_W'(count_reg) >= cap_eff);
    assign stat.at_end      = (pos_reg == count_reg);
    assign stat.key_eq      = (rdata_reg == key_reg);
    assign stat.key_ge      = (rdata_reg >= key_reg);
    assign stat.idx_ok      = (CMP_W'(ridx_reg) < CMP_W'(count_reg));
    assign stat.result_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> !stat.full)
        else $error("insert completed into a full table");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_pos <= count_reg))
        else $error("table write above the stored entries");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> stat.result_free)
        else $error("result loaded over an undelivered transaction");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sset_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PRINT_LIMIT    = 100;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 config_write = 1'b0;
    logic [CAP_W-1:0]     config_data  = CAP_RESET;

    // shadow copy of the table, count and capacity register
    logic signed [KEY_W-1:0] key_tbl [DEFAULT_DEPTH];
    int                      key_cnt = 0;
    logic [CAP_W-1:0]        cap_reg = CAP_RESET;

    result_t                 pending_results [$];
    int                      mismatches      = 0;
    int                      send_idle_pct   = 0;
    int                      recv_stall_pct  = 0;
    int                      quiet_cycles    = 0;

    always #10 clk = ~clk;

    sorted_set_insert_delete #(
        .DEPTH(DEFAULT_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .config_write(config_write),
        .config_data (config_data)
    );

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // apply one transaction to the shadow table and return its outcome
    function automatic result_t apply_item(item_t it);
        result_t r;
        int      pos;
        int      lim;
        r.status     = ST_OK;
        r.read_value = '0;
        lim = (cap_reg < DEFAULT_DEPTH) ? int'(cap_reg) : DEFAULT_DEPTH;
        pos = 0;
        while (pos < key_cnt && key_tbl[RIDX_W'(pos)] < it.key_value)
            pos++;
        case (it.command)
            CMD_INSERT:
            begin
                if (key_cnt >= lim)
                    r.status = ST_FULL;
                else if (pos < key_cnt && key_tbl[RIDX_W'(pos)] == it.key_value)
                    r.status = ST_DUP;
                else
                begin
                    for (int j = key_cnt; j > pos; j--)
                        key_tbl[RIDX_W'(j)] = key_tbl[RIDX_W'(j-1)];
                    key_tbl[RIDX_W'(pos)] = it.key_value;
                    key_cnt++;
                end
            end
            CMD_DELETE:
            begin
                if (pos >= key_cnt || key_tbl[RIDX_W'(pos)] != it.key_value)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j + 1 < key_cnt; j++)
                        key_tbl[RIDX_W'(j)] = key_tbl[RIDX_W'(j+1)];
                    key_cnt--;
                end
            end
            CMD_READ:
            begin
                if (int'(it.read_index) < key_cnt)
                    r.read_value = key_tbl[it.read_index];
                else
                    r.status = ST_BAD_INDEX;
            end
            default: ;
        endcase
        r.entry_count = COUNT_OUT_W'(key_cnt);
        return r;
    endfunction

    function automatic item_t make_item(cmd_t cmd, logic signed [KEY_W-1:0] key,
                                        int idx);
        item_t it;
        it.command    = cmd;
        it.key_value  = key;
        it.read_index = RIDX_W'(idx);
        return it;
    endfunction

    // hold valid across back-to-back transactions; drop it only for idle gaps
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(apply_item(it));
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        config_write <= 1'b1;
        config_data  <= value;
        @(posedge clk);
        config_write <= 1'b0;
        cap_reg = value;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = int'($urandom_range(63)) - 32;
            1:
            begin
                case ($urandom_range(5))
                    0: k = KEY_MIN;
                    1: k = KEY_MIN + 1;
                    2: k = KEY_MAX;
                    3: k = KEY_MAX - 1;
                    4: k = 0;
                    default: k = -1;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic signed [KEY_W-1:0] stored_key();
        return key_tbl[RIDX_W'($urandom_range(key_cnt - 1))];
    endfunction

    task automatic run_random_phase(input int n, input int ins_pct);
        item_t                   it;
        int                      roll;
        logic signed [KEY_W-1:0] key;
        int                      idx;
        repeat (n)
        begin
            roll = $urandom_range(99);
            key  = fresh_key();
            idx  = $urandom_range(63);
            if ($urandom_range(99) < 3)
                it = make_item(CMD_NOP, $urandom, $urandom_range(63));
            else if (roll < ins_pct)
            begin
                if (key_cnt > 0 && $urandom_range(99) < 20)
                    key = stored_key();
                it = make_item(CMD_INSERT, key, idx);
            end
            else if (roll < ins_pct + (100 - ins_pct) / 2)
            begin
                if (key_cnt > 0 && $urandom_range(99) < 70)
                    key = stored_key();
                it = make_item(CMD_DELETE, key, idx);
            end
            else
            begin
                if (key_cnt > 0 && $urandom_range(3) != 0)
                    idx = $urandom_range(key_cnt - 1);
                it = make_item(CMD_READ, key, idx);
            end
            send_item(it);
        end
    endtask

    task automatic test_after_reset();
        send_item(make_item(CMD_READ, 0, 0));
        send_item(make_item(CMD_DELETE, 5, 0));
        send_item(make_item(CMD_NOP, -1, 63));
    endtask

    task automatic test_key_extremes();
        send_item(make_item(CMD_INSERT, KEY_MIN, 0));
        send_item(make_item(CMD_INSERT, KEY_MAX, 63));
        send_item(make_item(CMD_INSERT, 0, 0));
        send_item(make_item(CMD_INSERT, -1, 0));
        send_item(make_item(CMD_INSERT, 1, 0));
        send_item(make_item(CMD_INSERT, KEY_MAX, 0));
        send_item(make_item(CMD_INSERT, KEY_MIN, 0));
        send_item(make_item(CMD_READ, 0, 0));
        send_item(make_item(CMD_READ, 0, 4));
        send_item(make_item(CMD_READ, 0, 5));
        send_item(make_item(CMD_READ, -1, 63));
        send_item(make_item(CMD_DELETE, -1, 0));
        send_item(make_item(CMD_DELETE, -1, 0));
        send_item(make_item(CMD_DELETE, KEY_MAX, 0));
        send_item(make_item(CMD_DELETE, KEY_MIN, 0));
    endtask

    // capacity dropped under the count, then to zero, then above the table depth
    task automatic test_capacity_edges();
        set_capacity(7'd1);
        send_item(make_item(CMD_INSERT, 7, 0));
        send_item(make_item(CMD_READ, 0, 1));
        send_item(make_item(CMD_DELETE, 1, 0));
        send_item(make_item(CMD_INSERT, 7, 0));
        set_capacity(7'd0);
        send_item(make_item(CMD_INSERT, 3, 0));
        send_item(make_item(CMD_DELETE, 0, 0));
        send_item(make_item(CMD_INSERT, 3, 0));
        set_capacity(7'd127);
        send_item(make_item(CMD_INSERT, 42, 0));
    endtask

    task automatic test_fill_to_full();
        set_capacity(7'd64);
        set_idling(0, 0);
        run_random_phase(225, 72);
    endtask

    task automatic test_sender_gaps();
        set_capacity(7'd127);
        set_idling(65, 0);
        run_random_phase(225, 55);
    endtask

    task automatic test_receiver_stalls();
        set_capacity(7'd10);
        set_idling(0, 65);
        run_random_phase(225, 50);
    endtask

    task automatic test_drain_at_zero_capacity();
        set_capacity(7'd0);
        set_idling(22, 22);
        run_random_phase(225, 30);
    endtask

    task automatic test_mid_capacity();
        set_capacity(7'd33);
        set_idling(0, 0);
        run_random_phase(225, 60);
    endtask

    task automatic test_mixed_traffic();
        set_capacity(7'd64);
        set_idling(22, 22);
        run_random_phase(225, 65);
    endtask

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no pending transaction");
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              result.status, exp_r.status));
                if (result.entry_count !== exp_r.entry_count)
                    report_mismatch($sformatf("entry_count got %0d exp %0d",
                                              result.entry_count, exp_r.entry_count));
                if (result.read_value !== exp_r.read_value)
                    report_mismatch($sformatf("read_value got %0d exp %0d",
                                              result.read_value, exp_r.read_value));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_key_extremes();
        test_capacity_edges();
        test_fill_to_full();
        test_sender_gaps();
        test_receiver_stalls();
        test_drain_at_zero_capacity();
        test_mid_capacity();
        test_mixed_traffic();

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/sset_pkg.sv
rtl/core/sset_ctrl.sv
rtl/core/sset_dp.sv
rtl/core/sorted_set_insert_delete.sv
test/testbench.sv
